// ----- rtl/rc4_pkg.sv -----
// Shared constants for the RC4 stream cipher engine.
// No dependencies; used by rc4_stream_cipher.

package rc4_pkg;

  localparam int BYTE_W = 8;
  localparam int PERM_DEPTH = 256;
  localparam int KEY_DEPTH_DEFAULT = 256;
  localparam logic [BYTE_W-1:0] PERM_LAST = 8'd255;

endpackage

// ----- rtl/rc4_stream_cipher.sv -----
// RC4 stream cipher engine with the permutation and the key in on-chip memories.
// Depends on rc4_pkg for byte width, permutation depth and the default key depth.
//
// Usage:
// The input channel (in_valid, in_stall) carries one beat per byte. With kind low,
// the beat is a key byte and is stored; a key byte with last high starts the key
// schedule. With kind high, the beat is a data byte and yields exactly one output
// beat (out_valid, out_stall) with the XORed byte, the keystream byte and last.
// Key beats yield no output beat.
// A key beat that starts the schedule holds in_stall high while steps K0 to K3 run
// once per permutation entry. A data beat passes D1, D2 and D3 after acceptance and
// then enters the output register; no new beat is accepted until it leaves D3. Each
// generator step needs three reads and two writes of the permutation memory and each
// schedule step two reads and two writes; the memory has one read and one write port.
// The output register lets a new beat be accepted while a result waits. When the
// receiver stalls and the output register is still full, the next data beat waits
// in its last step and holds in_stall high until the register frees.
// Reset restores the identity permutation at once through per-entry valid bits,
// clears i, j and the key count, and empties the output register.

module rc4_stream_cipher #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [rc4_pkg::BYTE_W-1:0] value,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte,
  output logic [rc4_pkg::BYTE_W-1:0] keystream_byte,
  output logic                       last_out
);

  localparam int BW  = rc4_pkg::BYTE_W;
  localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KCW = $clog2(KEY_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_D1, S_D2, S_D3, S_K0, S_K1, S_K2, S_K3
  } state_t;

  state_t state;

  logic [BW-1:0]  idx_i;
  logic [BW-1:0]  idx_j;
  logic [KCW-1:0] key_count;
  logic [KAW-1:0] kidx;
  logic [BW-1:0]  si;
  logic [BW-1:0]  sj;
  logic           fwd_i;
  logic           fwd_j;
  logic [BW-1:0]  data_q;
  logic           last_q;

  logic [BW-1:0]  perm_mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0] perm_vld;
  logic [BW-1:0]  perm_q;
  logic           perm_vld_q;
  logic [BW-1:0]  perm_raddr_q;
  logic [BW-1:0]  perm_rd;

  logic [BW-1:0]  key_mem [KEY_DEPTH];
  logic [BW-1:0]  key_q;

  logic           accept;
  logic           pm_re;
  logic [BW-1:0]  pm_raddr;
  logic           pm_we;
  logic [BW-1:0]  pm_waddr;
  logic [BW-1:0]  pm_wdata;
  logic           pm_clr;
  logic           key_re;
  logic           key_we;
  logic [BW-1:0]  key_byte;
  logic [BW-1:0]  j_data;
  logic [BW-1:0]  j_sched;
  logic [BW-1:0]  sum;
  logic [BW-1:0]  ks;
  logic           out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pm_clr   = accept && !kind && last;
  assign key_we   = accept && !kind && (key_count < KCW'(KEY_DEPTH));
  assign key_re   = (state == S_K0);

  // An entry that has not been written since reset or since the schedule began
  // still holds its identity value.
  assign perm_rd  = perm_vld_q ? perm_q : perm_raddr_q;
  assign key_byte = (key_count == '0) ? '0 : key_q;
  assign j_data   = idx_j + perm_rd;
  assign j_sched  = idx_j + perm_rd + key_byte;
  assign sum      = si + perm_rd;
  assign ks       = fwd_j ? si : (fwd_i ? sj : perm_rd);

  always_comb begin
    pm_re    = 1'b0;
    pm_raddr = idx_i;
    pm_we    = 1'b0;
    pm_waddr = idx_i;
    pm_wdata = perm_rd;
    unique case (state)
      S_IDLE: begin
        pm_re    = 1'b1;
        pm_raddr = idx_i + BW'(1);
      end
      S_D1: begin
        pm_re    = 1'b1;
        pm_raddr = j_data;
      end
      S_D2: begin
        pm_re    = 1'b1;
        pm_raddr = sum;
        pm_we    = 1'b1;
        pm_waddr = idx_i;
        pm_wdata = perm_rd;
      end
      S_D3: begin
        pm_we    = 1'b1;
        pm_waddr = idx_j;
        pm_wdata = si;
      end
      S_K0: begin
        pm_re    = 1'b1;
        pm_raddr = idx_i;
      end
      S_K1: begin
        pm_re    = 1'b1;
        pm_raddr = j_sched;
      end
      S_K2: begin
        pm_we    = 1'b1;
        pm_waddr = idx_i;
        pm_wdata = perm_rd;
      end
      S_K3: begin
        pm_we    = 1'b1;
        pm_waddr = idx_j;
        pm_wdata = si;
      end
      default: begin
        pm_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      perm_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      perm_q       <= perm_mem[pm_raddr];
      perm_vld_q   <= perm_vld[pm_raddr];
      perm_raddr_q <= pm_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || pm_clr) begin
      perm_vld <= '0;
    end else if (pm_we) begin
      perm_vld[pm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count[KAW-1:0]] <= value;
    end
    if (key_re) begin
      key_q <= key_mem[kidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      key_count <= '0;
      kidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_D3) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind) begin
              idx_i  <= idx_i + BW'(1);
              data_q <= value;
              last_q <= last;
              state  <= S_D1;
            end else begin
              if (key_we) begin
                key_count <= key_count + KCW'(1);
              end
              if (last) begin
                idx_i <= '0;
                idx_j <= '0;
                kidx  <= '0;
                state <= S_K0;
              end
            end
          end
        end
        S_D1: begin
          si    <= perm_rd;
          idx_j <= j_data;
          state <= S_D2;
        end
        S_D2: begin
          sj    <= perm_rd;
          fwd_j <= (sum == idx_j);
          fwd_i <= (sum == idx_i);
          state <= S_D3;
        end
        S_D3: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_byte       <= data_q ^ ks;
            keystream_byte <= ks;
            last_out       <= last_q;
            state          <= S_IDLE;
          end
        end
        S_K0: begin
          state <= S_K1;
        end
        S_K1: begin
          si    <= perm_rd;
          idx_j <= j_sched;
          state <= S_K2;
        end
        S_K2: begin
          state <= S_K3;
        end
        S_K3: begin
          if (idx_i == rc4_pkg::PERM_LAST) begin
            idx_i     <= '0;
            idx_j     <= '0;
            key_count <= '0;
            state     <= S_IDLE;
          end else begin
            idx_i <= idx_i + BW'(1);
            if (KCW'(kidx) + KCW'(1) == key_count) begin
              kidx <= '0;
            end else begin
              kidx <= kidx + KAW'(1);
            end
            state <= S_K0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_data_walk : assert property (@(posedge clk) disable iff (rst)
    (accept && kind) |=> (state == S_D1) ##1 (state == S_D2) ##1 (state == S_D3))
    else $error("data beat did not walk through the generator steps");

  a_clear_no_write : assert property (@(posedge clk) disable iff (rst)
    !(pm_clr && pm_we))
    else $error("permutation cleared while a write is in flight");

  a_sched_end : assert property (@(posedge clk) disable iff (rst)
    (state == S_K3 && idx_i == rc4_pkg::PERM_LAST) |=>
      (state == S_IDLE && key_count == '0 && idx_i == '0 && idx_j == '0))
    else $error("key schedule did not finish cleanly");

  a_key_count_range : assert property (@(posedge clk) disable iff (rst)
    key_count <= KCW'(KEY_DEPTH))
    else $error("key count beyond key store depth");

  a_result_only_from_data : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_D3))
    else $error("result appeared outside the generator path");
`endif

endmodule
